[sv/jdc_pkg.sv]
// shared types, constants and helper functions of the joystick drive controller
package jdc_pkg;

  localparam int MAX_GEARS = 4;

  localparam int GEAR_W  = 2;
  localparam int SPEED_W = 10;
  localparam int DIFF_W  = 7;
  localparam int PROD_W  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // button codes
  localparam logic [7:0] BTN_DOWN = 8'd1;
  localparam logic [7:0] BTN_UP   = 8'd2;

  // direction thresholds; x limits are the remapped thresholds folded back onto the swapped byte
  localparam logic [7:0] FWD_Y_MIN    = 8'd210;
  localparam logic [7:0] BACK_Y_MAX   = 8'd80;
  localparam logic [7:0] RIGHT_X_MIN  = 8'd175;
  localparam logic [7:0] LEFT_X_MAX   = 8'd61;

  // throttle dead zone upper edge
  localparam logic [7:0] THROTTLE_ZERO_MAX = 8'd130;

  // divide by 56: shift by 3, then multiply by reciprocal of 7
  localparam int DIV8_SHIFT  = 3;
  localparam int RECIP7      = 4682;
  localparam int RECIP7_SHIFT = 15;
  localparam int QUOT_W      = PROD_W - DIV8_SHIFT;
  localparam int RPROD_W     = QUOT_W + 13;

  // reset values of the registers
  localparam logic [2:0]  GEAR_COUNT_RST  = 3'd4;
  localparam logic [15:0] DEBOUNCE_RST    = 16'd200;
  localparam logic [7:0]  ACCEL_STEP_RST  = 8'd2;

  typedef enum logic [2:0] {
    DIR_FORWARD    = 3'd0,
    DIR_BACKWARD   = 3'd1,
    DIR_SPIN_RIGHT = 3'd2,
    DIR_SPIN_LEFT  = 3'd3,
    DIR_STOPPED    = 3'd4
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEAR_SPEED_ZERO  = 3'd0,
    REG_GEAR_SPEED_ONE   = 3'd1,
    REG_GEAR_SPEED_TWO   = 3'd2,
    REG_GEAR_SPEED_THREE = 3'd3,
    REG_GEAR_COUNT       = 3'd4,
    REG_DEBOUNCE_MS      = 3'd5,
    REG_ACCEL_STEP       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_GEARS-1:0][7:0] gear_speed;
    logic [2:0]                gear_count;
    logic [15:0]               debounce_ms;
    logic [7:0]                accel_step;
  } cfg_t;

  // after the shift stage
  typedef struct packed {
    dir_t              dir;
    logic [GEAR_W-1:0] gear;
    logic [DIFF_W-1:0] throttle;
    logic [7:0]        top;
  } shift_t;

  // after the product stage
  typedef struct packed {
    dir_t              dir;
    logic [GEAR_W-1:0] gear;
    logic [PROD_W-1:0] prod;
  } prod_t;

  // after the divide stage
  typedef struct packed {
    dir_t               dir;
    logic [GEAR_W-1:0]  gear;
    logic [SPEED_W-1:0] target;
  } target_t;

  function automatic logic [7:0] swap_nibbles(input logic [7:0] x);
    return {x[3:0], x[7:4]};
  endfunction

  function automatic dir_t pick_direction(input logic [7:0] lx, input logic [7:0] ly);
    logic [7:0] sx;
    dir_t       d;
    sx = swap_nibbles(lx);
    if (ly > FWD_Y_MIN)        d = DIR_FORWARD;
    else if (ly < BACK_Y_MAX)  d = DIR_BACKWARD;
    else if (sx >= RIGHT_X_MIN) d = DIR_SPIN_RIGHT;
    else if (sx <= LEFT_X_MAX) d = DIR_SPIN_LEFT;
    else                       d = DIR_STOPPED;
    return d;
  endfunction

  // highest gear index allowed by the gear count
  function automatic logic [GEAR_W-1:0] gear_limit(input logic [2:0] gc);
    logic [2:0] n;
    n = gc;
    if (n < 3'd1) n = 3'd1;
    if (n > 3'(MAX_GEARS)) n = 3'(MAX_GEARS);
    return GEAR_W'(n - 3'd1);
  endfunction

endpackage

[sv/jdc_cfg_regs.sv]
// configuration register file
module jdc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [jdc_pkg::CFG_DATA_W-1:0] wr_data,
  output jdc_pkg::cfg_t                  cfg
);

  jdc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        jdc_pkg::REG_GEAR_SPEED_ZERO:  cfg_nxt.gear_speed[0] = wr_data[7:0];
        jdc_pkg::REG_GEAR_SPEED_ONE:   cfg_nxt.gear_speed[1] = wr_data[7:0];
        jdc_pkg::REG_GEAR_SPEED_TWO:   cfg_nxt.gear_speed[2] = wr_data[7:0];
        jdc_pkg::REG_GEAR_SPEED_THREE: cfg_nxt.gear_speed[3] = wr_data[7:0];
        jdc_pkg::REG_GEAR_COUNT:       cfg_nxt.gear_count    = wr_data[2:0];
        jdc_pkg::REG_DEBOUNCE_MS:      cfg_nxt.debounce_ms   = wr_data[15:0];
        jdc_pkg::REG_ACCEL_STEP:       cfg_nxt.accel_step    = wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gear_speed  <= '0;
      cfg_r.gear_count  <= jdc_pkg::GEAR_COUNT_RST;
      cfg_r.debounce_ms <= jdc_pkg::DEBOUNCE_RST;
      cfg_r.accel_step  <= jdc_pkg::ACCEL_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/jdc_shift_ctrl.sv]
// debounced gear shifting, direction pick and throttle offset
module jdc_shift_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [7:0]          button_code,
  input  logic [7:0]          left_stick_x,
  input  logic [7:0]          left_stick_y,
  input  logic [7:0]          right_stick_y,
  input  logic [31:0]         time_stamp,
  input  jdc_pkg::cfg_t       cfg,
  output jdc_pkg::shift_t     shift_out
);

  logic [jdc_pkg::GEAR_W-1:0] gear_r, gear_nxt;
  logic [31:0]                last_down_r, last_down_nxt;
  logic [31:0]                last_up_r, last_up_nxt;
  jdc_pkg::shift_t            shift_r, shift_nxt;

  logic [31:0]                down_gap, up_gap;
  logic [jdc_pkg::GEAR_W-1:0] lim;
  logic [jdc_pkg::GEAR_W:0]   up_gear;

  always_comb begin
    down_gap = time_stamp - last_down_r;
    up_gap   = time_stamp - last_up_r;
    lim      = jdc_pkg::gear_limit(cfg.gear_count);
    up_gear  = {1'b0, gear_r} + 3'd1;

    gear_nxt      = gear_r;
    last_down_nxt = last_down_r;
    last_up_nxt   = last_up_r;
    if (button_code == jdc_pkg::BTN_DOWN && down_gap > {16'd0, cfg.debounce_ms}) begin
      if (gear_r != '0) gear_nxt = gear_r - 2'd1;
      last_down_nxt = time_stamp;
    end else if (button_code == jdc_pkg::BTN_UP && up_gap > {16'd0, cfg.debounce_ms}) begin
      gear_nxt    = (up_gear < {1'b0, lim}) ? up_gear[jdc_pkg::GEAR_W-1:0] : lim;
      last_up_nxt = time_stamp;
    end

    shift_nxt.dir  = jdc_pkg::pick_direction(left_stick_x, left_stick_y);
    shift_nxt.gear = gear_nxt;
    shift_nxt.top  = cfg.gear_speed[gear_nxt];
    if (right_stick_y <= jdc_pkg::THROTTLE_ZERO_MAX) begin
      shift_nxt.throttle = '0;
    end else begin
      shift_nxt.throttle = jdc_pkg::DIFF_W'(right_stick_y - jdc_pkg::THROTTLE_ZERO_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r      <= '0;
      last_down_r <= '0;
      last_up_r   <= '0;
    end else if (en) begin
      gear_r      <= gear_nxt;
      last_down_r <= last_down_nxt;
      last_up_r   <= last_up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shift_r <= shift_nxt;
    end
  end

  assign shift_out = shift_r;

endmodule

[sv/jdc_throttle.sv]
// target speed: throttle times top speed, then divide by 56
module jdc_throttle (
  input  logic              clk,
  input  logic              prod_en,
  input  logic              div_en,
  input  jdc_pkg::shift_t   shift_in,
  output jdc_pkg::target_t  target_out
);

  jdc_pkg::prod_t   prod_r, prod_nxt;
  jdc_pkg::target_t target_r, target_nxt;

  logic [jdc_pkg::QUOT_W-1:0]  quot8;
  logic [jdc_pkg::RPROD_W-1:0] rprod;

  always_comb begin
    prod_nxt.dir  = shift_in.dir;
    prod_nxt.gear = shift_in.gear;
    prod_nxt.prod = jdc_pkg::PROD_W'(shift_in.throttle * shift_in.top);
  end

  // floor(p / 56) = floor(floor(p / 8) / 7), reciprocal exact below 5461
  always_comb begin
    quot8 = prod_r.prod[jdc_pkg::PROD_W-1:jdc_pkg::DIV8_SHIFT];
    rprod = jdc_pkg::RPROD_W'(quot8) * jdc_pkg::RPROD_W'(jdc_pkg::RECIP7);
    target_nxt.dir    = prod_r.dir;
    target_nxt.gear   = prod_r.gear;
    target_nxt.target = jdc_pkg::SPEED_W'(rprod >> jdc_pkg::RECIP7_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
    if (div_en) begin
      target_r <= target_nxt;
    end
  end

  assign target_out = target_r;

endmodule

[sv/jdc_ramp.sv]
// speed ramp toward the target and the result register
module jdc_ramp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  jdc_pkg::target_t                target_in,
  input  logic [7:0]                      accel_step,
  output logic [2:0]                      direction,
  output logic [jdc_pkg::SPEED_W-1:0]     drive_speed,
  output logic [jdc_pkg::GEAR_W-1:0]      gear_now
);

  logic [jdc_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  jdc_pkg::dir_t               dir_r;
  logic [jdc_pkg::GEAR_W-1:0]  gear_r;

  logic [jdc_pkg::SPEED_W:0]   speed_up;
  logic [jdc_pkg::SPEED_W-1:0] gap;
  logic [jdc_pkg::SPEED_W-1:0] step;

  always_comb begin
    step      = jdc_pkg::SPEED_W'(accel_step);
    speed_up  = {1'b0, speed_r} + {1'b0, step};
    gap       = speed_r - target_in.target;
    speed_nxt = speed_r;
    if (speed_r < target_in.target) begin
      speed_nxt = (speed_up < {1'b0, target_in.target}) ?
                  speed_up[jdc_pkg::SPEED_W-1:0] : target_in.target;
    end else if (speed_r > target_in.target) begin
      speed_nxt = (gap > step) ? speed_r - step : target_in.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (en) begin
      speed_r <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r  <= target_in.dir;
      gear_r <= target_in.gear;
    end
  end

  assign direction   = dir_r;
  assign drive_speed = speed_r;
  assign gear_now    = gear_r;

endmodule

[sv/joystick_drive_controller_unit.sv]
// top level of the joystick drive controller
// Turns one controller poll per item into a drive direction, a ramped motor
// speed and the gear in use. A new item is taken every clock cycle while in_stall
// is low; each item runs through five registers (input, shift, product, divide,
// result). The gear and debounce times are updated in the shift stage and the
// speed in the result stage, each as a single registered update, which is what
// lets polls follow one another with no gap. Every stage has its own valid bit
// and only holds when the stage after it is full and held, so the input keeps
// taking items while a finished result waits at the output. Button 1 shifts down
// and button 2 up, each only if more than debounce_ms milliseconds passed since
// that button's last accepted press. The right stick above 130 sets the target
// speed (right_y - 130) * top / 56, and the speed moves by at most accel_step per
// item. Configuration writes are always taken (cfg_ready stays high) and must
// be made only while no item is in flight.
module joystick_drive_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // poll items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_button_code,
  input  logic [7:0]                     in_left_stick_x,
  input  logic [7:0]                     in_left_stick_y,
  input  logic [7:0]                     in_right_stick_y,
  input  logic [31:0]                    in_time_stamp,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_direction,
  output logic [jdc_pkg::SPEED_W-1:0]    out_drive_speed,
  output logic [jdc_pkg::GEAR_W-1:0]     out_gear_now,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  jdc_pkg::cfg_t    cfg;
  jdc_pkg::shift_t  shift_q;
  jdc_pkg::target_t target_q;

  // per-stage valid bits: input, shift, product, divide, result
  logic in_v_r, in_v_nxt;
  logic sh_v_r, sh_v_nxt;
  logic pr_v_r, pr_v_nxt;
  logic dv_v_r, dv_v_nxt;
  logic out_v_r, out_v_nxt;

  // a stage can load when it is empty or its content moves on
  logic out_rdy, dv_rdy, pr_rdy, sh_rdy, in_rdy;
  logic in_en, sh_en, pr_en, dv_en, out_en;

  // input register
  logic [7:0]  btn_r, lx_r, ly_r, ry_r;
  logic [31:0] ts_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    out_rdy = !out_v_r || !out_stall;
    dv_rdy  = !dv_v_r || out_rdy;
    pr_rdy  = !pr_v_r || dv_rdy;
    sh_rdy  = !sh_v_r || pr_rdy;
    in_rdy  = !in_v_r || sh_rdy;

    in_en  = in_valid && in_rdy;
    sh_en  = in_v_r && sh_rdy;
    pr_en  = sh_v_r && pr_rdy;
    dv_en  = pr_v_r && dv_rdy;
    out_en = dv_v_r && out_rdy;

    in_v_nxt  = in_rdy  ? in_valid : in_v_r;
    sh_v_nxt  = sh_rdy  ? in_v_r   : sh_v_r;
    pr_v_nxt  = pr_rdy  ? sh_v_r   : pr_v_r;
    dv_v_nxt  = dv_rdy  ? pr_v_r   : dv_v_r;
    out_v_nxt = out_rdy ? dv_v_r   : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      sh_v_r  <= 1'b0;
      pr_v_r  <= 1'b0;
      dv_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      sh_v_r  <= sh_v_nxt;
      pr_v_r  <= pr_v_nxt;
      dv_v_r  <= dv_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // capture the poll
  always_ff @(posedge clk) begin
    if (in_en) begin
      btn_r <= in_button_code;
      lx_r  <= in_left_stick_x;
      ly_r  <= in_left_stick_y;
      ry_r  <= in_right_stick_y;
      ts_r  <= in_time_stamp;
    end
  end

  assign in_stall  = !in_rdy;
  assign out_valid = out_v_r;

  jdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // gear state, debounce and direction
  jdc_shift_ctrl u_shift (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (sh_en),
    .button_code   (btn_r),
    .left_stick_x  (lx_r),
    .left_stick_y  (ly_r),
    .right_stick_y (ry_r),
    .time_stamp    (ts_r),
    .cfg           (cfg),
    .shift_out     (shift_q)
  );

  // target speed over two registered steps
  jdc_throttle u_throttle (
    .clk        (clk),
    .prod_en    (pr_en),
    .div_en     (dv_en),
    .shift_in   (shift_q),
    .target_out (target_q)
  );

  // speed state and result register
  jdc_ramp u_ramp (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (out_en),
    .target_in   (target_q),
    .accel_step  (cfg.accel_step),
    .direction   (out_direction),
    .drive_speed (out_drive_speed),
    .gear_now    (out_gear_now)
  );

endmodule

[sv/jdc_checker.sv]
// port-level checks of the joystick drive controller, bound to the top level
module jdc_port_checks (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [2:0]                     out_direction,
  input logic [jdc_pkg::SPEED_W-1:0]    out_drive_speed,
  input logic [jdc_pkg::GEAR_W-1:0]     out_gear_now
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a held result stays
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result does not change
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_direction) && $stable(out_drive_speed) && $stable(out_gear_now))
    else $error("result changed while stalled");

  // direction is a defined code
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_direction <= 3'(jdc_pkg::DIR_STOPPED))
    else $error("direction code out of range");

  // ramp never passes the largest target of 125 * 255 / 56
  a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_speed <= 10'd569)
    else $error("drive speed above largest target");

endmodule

bind joystick_drive_controller_unit jdc_port_checks u_jdc_port_checks (.*);

[bench/jdc_checker.sv]
// checker of the joystick drive controller: predicts each drive command and compares results
module jdc_checker
  import jdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_button_code,
  input  logic [7:0]            in_left_stick_x,
  input  logic [7:0]            in_left_stick_y,
  input  logic [7:0]            in_right_stick_y,
  input  logic [31:0]           in_time_stamp,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [2:0]            out_direction,
  input  logic [SPEED_W-1:0]    out_drive_speed,
  input  logic [GEAR_W-1:0]     out_gear_now,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dir_t               dir;
    logic [SPEED_W-1:0] speed;
    logic [GEAR_W-1:0]  gear;
  } drive_cmd_t;

  // register copies
  logic [7:0]  top_speed [MAX_GEARS];
  logic [2:0]  gears_used;
  logic [15:0] debounce;
  logic [7:0]  ramp_step;

  // controller state
  logic [GEAR_W-1:0]  gear;
  logic [SPEED_W-1:0] speed;
  logic [31:0]        last_down;
  logic [31:0]        last_up;

  drive_cmd_t drive_queue [$];
  int         fails = 0;

  // direction from the left stick, x remapped with truncating division
  function automatic dir_t steer(input logic [7:0] lx, input logic [7:0] ly);
    logic [7:0] sx;
    int         mx;
    sx = {lx[3:0], lx[7:4]};
    mx = (int'(sx) - 55) * 115 / 160 + 75;
    if (ly > 8'd210) return DIR_FORWARD;
    if (ly < 8'd80) return DIR_BACKWARD;
    if (mx > 160) return DIR_SPIN_RIGHT;
    if (mx < 80) return DIR_SPIN_LEFT;
    return DIR_STOPPED;
  endfunction

  // one poll: gear shift, throttle target, speed ramp
  function automatic drive_cmd_t advance_drive(input logic [7:0] btn, input logic [7:0] lx,
                                               input logic [7:0] ly, input logic [7:0] ry,
                                               input logic [31:0] ts);
    drive_cmd_t  cmd;
    logic [31:0] since_down;
    logic [31:0] since_up;
    int          lim;
    int          nxt;
    int          target;
    since_down = ts - last_down;
    since_up   = ts - last_up;
    if (btn == BTN_DOWN && since_down > 32'(debounce)) begin
      if (gear != '0) gear = gear - 1'b1;
      last_down = ts;
    end else if (btn == BTN_UP && since_up > 32'(debounce)) begin
      if (gears_used == 3'd0) lim = 0;
      else if (int'(gears_used) > MAX_GEARS) lim = MAX_GEARS - 1;
      else lim = int'(gears_used) - 1;
      nxt  = int'(gear) + 1;
      gear = GEAR_W'((nxt < lim) ? nxt : lim);
      last_up = ts;
    end
    if (ry <= 8'd130) target = 0;
    else target = (int'(ry) - 130) * int'(top_speed[gear]) / 56;
    if (int'(speed) < target) begin
      nxt   = int'(speed) + int'(ramp_step);
      speed = SPEED_W'((nxt < target) ? nxt : target);
    end else if (int'(speed) > target) begin
      speed = SPEED_W'((int'(speed) - target > int'(ramp_step)) ?
                       int'(speed) - int'(ramp_step) : target);
    end
    cmd.dir   = steer(lx, ly);
    cmd.speed = speed;
    cmd.gear  = gear;
    return cmd;
  endfunction

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      foreach (top_speed[i]) top_speed[i] = 8'd0;
      gears_used = GEAR_COUNT_RST;
      debounce   = DEBOUNCE_RST;
      ramp_step  = ACCEL_STEP_RST;
      gear       = '0;
      speed      = '0;
      last_down  = '0;
      last_up    = '0;
      drive_queue.delete();
    end else begin
      // results first, so an item taken on this edge cannot be matched early
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          fails++;
          $display("%0t ns: result with no poll waiting: direction %0d speed %0d gear %0d",
                   $time, out_direction, out_drive_speed, out_gear_now);
        end else begin
          want = drive_queue.pop_front();
          if (out_direction !== want.dir) begin
            fails++;
            $display("%0t ns: direction expected %0d got %0d", $time, want.dir, out_direction);
          end
          if (out_drive_speed !== want.speed) begin
            fails++;
            $display("%0t ns: drive_speed expected %0d got %0d", $time, want.speed,
                     out_drive_speed);
          end
          if (out_gear_now !== want.gear) begin
            fails++;
            $display("%0t ns: gear_now expected %0d got %0d", $time, want.gear, out_gear_now);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GEAR_SPEED_ZERO:  top_speed[0] = cfg_data[7:0];
          REG_GEAR_SPEED_ONE:   top_speed[1] = cfg_data[7:0];
          REG_GEAR_SPEED_TWO:   top_speed[2] = cfg_data[7:0];
          REG_GEAR_SPEED_THREE: top_speed[3] = cfg_data[7:0];
          REG_GEAR_COUNT:       gears_used   = cfg_data[2:0];
          REG_DEBOUNCE_MS:      debounce     = cfg_data;
          REG_ACCEL_STEP:       ramp_step    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        drive_queue.push_back(advance_drive(in_button_code, in_left_stick_x, in_left_stick_y,
                                            in_right_stick_y, in_time_stamp));
    end
    outstanding <= drive_queue.size();
    mismatches  <= fails;
  end

endmodule

[bench/testbench.sv]
// top of the joystick drive controller testbench: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jdc_pkg::*;

  localparam int CLK_HALF        = 6;     // 12 ns period
  localparam int RESET_CYCLES    = 4;
  localparam int DRAIN_CYCLES    = 10;    // pipeline is five stages deep
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake on any channel
  localparam int RANDOM_PHASES   = 13;
  localparam int ITEMS_PER_PHASE = 100;

  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_button_code;
  logic [7:0]            in_left_stick_x;
  logic [7:0]            in_left_stick_y;
  logic [7:0]            in_right_stick_y;
  logic [31:0]           in_time_stamp;
  logic                  out_valid;
  logic                  out_stall;
  logic [2:0]            out_direction;
  logic [SPEED_W-1:0]    out_drive_speed;
  logic [GEAR_W-1:0]     out_gear_now;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  // stimulus state
  bit          no_idle;       // both sides run back to back when set
  logic [31:0] clock_ms;      // running poll time
  int          press_window;  // debounce setting of the current phase

  joystick_drive_controller_unit DUT (.*);

  jdc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // receiver: after each taken result, stall for a random number of cycles
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        hold = no_idle ? 0 : $urandom_range(0, 5);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog: any handshake restarts the count
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // one poll item; valid stays high on return so a following item can go back to back
  task automatic send_poll(input logic [7:0] btn, input logic [7:0] lx, input logic [7:0] ly,
                           input logic [7:0] ry, input logic [31:0] ts);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_button_code   <= btn;
    in_left_stick_x  <= lx;
    in_left_stick_y  <= ly;
    in_right_stick_y <= ry;
    in_time_stamp    <= ts;
    do @(posedge clk); while (in_stall);
  endtask

  // one register write; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all seven registers, junk in the unused upper data bits
  task automatic write_config(input logic [7:0] g0, input logic [7:0] g1, input logic [7:0] g2,
                              input logic [7:0] g3, input logic [2:0] gc,
                              input logic [15:0] deb, input logic [7:0] step);
    write_reg(REG_GEAR_SPEED_ZERO,  {8'($urandom), g0});
    write_reg(REG_GEAR_SPEED_ONE,   {8'($urandom), g1});
    write_reg(REG_GEAR_SPEED_TWO,   {8'($urandom), g2});
    write_reg(REG_GEAR_SPEED_THREE, {8'($urandom), g3});
    write_reg(REG_GEAR_COUNT,       {13'($urandom), gc});
    write_reg(REG_DEBOUNCE_MS,      deb);
    write_reg(REG_ACCEL_STEP,       {8'($urandom), step});
    cfg_valid <= 1'b0;
    press_window = int'(deb);
  endtask

  // stop sending and wait until every poll has its result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);  // the checker's count is registered
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // per-phase settings; the first two phases pin the extremes
  task automatic random_config(input int phase);
    logic [7:0]  g [MAX_GEARS];
    logic [2:0]  gc;
    logic [15:0] deb;
    logic [7:0]  step;
    foreach (g[i])
      g[i] = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0)
                                         : 8'($urandom);
    gc = 3'($urandom);
    case ($urandom_range(0, 5))
      0:       deb = 16'd0;
      1:       deb = 16'hFFFF;
      2:       deb = 16'($urandom);
      default: deb = 16'($urandom_range(0, 300));
    endcase
    step = ($urandom_range(0, 4) == 0) ? 8'd1 : 8'($urandom);
    if (phase == 0) begin
      foreach (g[i]) g[i] = 8'd255;
      gc   = 3'd4;
      deb  = 16'hFFFF;
      step = 8'd255;
    end else if (phase == 1) begin
      foreach (g[i]) g[i] = 8'd255;
      gc   = 3'd1;
      deb  = 16'd0;
      step = 8'd1;
    end
    write_config(g[0], g[1], g[2], g[3], gc, deb, step);
  endtask

  // mostly gear presses, time advancing around the debounce window, sticks anywhere
  task automatic random_poll();
    logic [7:0] btn;
    int         roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) btn = BTN_DOWN;
    else if (roll < 8) btn = BTN_UP;
    else btn = 8'($urandom);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + 32'($urandom_range(0, 2 * press_window + 2));
    send_poll(btn, 8'($urandom), 8'($urandom), 8'($urandom), clock_ms);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_button_code   <= '0;
    in_left_stick_x  <= '0;
    in_left_stick_y  <= '0;
    in_right_stick_y <= '0;
    in_time_stamp    <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    no_idle      = 1'b0;
    clock_ms     = '0;
    press_window = int'(DEBOUNCE_RST);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero top speeds, four gears, 200 ms debounce
    send_poll(BTN_UP,   8'h00, 8'd0,   8'd255, 32'd201);  // just past debounce, gear up
    send_poll(BTN_DOWN, 8'hFF, 8'd255, 8'd110, 32'd201);  // dead zone y=110
    settle();

    write_reg(REG_UNUSED, 16'hFFFF);
    write_config(8'd50, 8'd120, 8'd200, 8'd255, 3'd4, 16'd200, 8'd255);
    send_poll(BTN_UP,   8'hFA, 8'd150, 8'd186, 32'd500);  // swapped x 175, first spin right
    send_poll(BTN_UP,   8'hEA, 8'd150, 8'd131, 32'd550);  // debounced; x 174 stays stopped
    send_poll(BTN_UP,   8'hD3, 8'd210, 8'd130, 32'd701);  // elapsed 201; x 61 spins left
    send_poll(BTN_UP,   8'hE3, 8'd211, 8'd255, 32'd901);  // elapsed exactly 200 is held off
    send_poll(BTN_UP,   8'h00, 8'd80,  8'd255, 32'd1200); // top gear, y 80 not backward
    send_poll(BTN_UP,   8'hFF, 8'd79,  8'd255, 32'd1500); // clamp at top gear
    send_poll(BTN_DOWN, 8'hE3, 8'd100, 8'd255, 32'd1501); // x 62 lands on stopped
    send_poll(BTN_DOWN, 8'h5A, 8'd100, 8'd200, 32'd1600); // debounced down
    send_poll(8'd0,     8'hA5, 8'd120, 8'd0,   32'd1700); // other button codes do nothing
    send_poll(8'd3,     8'h77, 8'd220, 8'd140, 32'd1800);
    send_poll(8'd255,   8'h88, 8'd60,  8'd170, 32'd1900);
    // elapsed time wraps around zero
    send_poll(BTN_UP,   8'h12, 8'd200, 8'd255, 32'hFFFF_FFF0);
    send_poll(BTN_UP,   8'h34, 8'd200, 8'd255, 32'h0000_00B8);
    send_poll(BTN_UP,   8'h56, 8'd200, 8'd255, 32'h0000_00B9);
    settle();

    // gear count cut below the held gear, no debounce
    write_config(8'd50, 8'd120, 8'd200, 8'd255, 3'd2, 16'd0, 8'd7);
    send_poll(BTN_DOWN, 8'h9C, 8'd150, 8'd255, 32'h0000_0100); // held gear above count drops one
    send_poll(BTN_UP,   8'h9C, 8'd150, 8'd255, 32'h0000_0100); // up snaps to count - 1
    send_poll(BTN_UP,   8'h9C, 8'd150, 8'd255, 32'h0000_0100); // zero elapsed is not a press
    settle();

    // gear count of zero, longest debounce, ramp frozen at step zero
    write_config(8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 16'hFFFF, 8'd0);
    send_poll(BTN_UP,   8'h41, 8'd230, 8'd255, 32'h0001_0100);
    send_poll(BTN_DOWN, 8'h14, 8'd30,  8'd0,   32'h0001_0100);
    settle();

    // gear count above the gear limit acts as four
    write_config(8'd255, 8'd255, 8'd255, 8'd255, 3'd7, 16'hFFFF, 8'd255);
    send_poll(BTN_UP, 8'hCF, 8'd255, 8'd255, 32'h0002_0200);
    send_poll(BTN_UP, 8'hCF, 8'd255, 8'd255, 32'h0003_0300);
    send_poll(BTN_UP, 8'hCF, 8'd255, 8'd255, 32'h0004_0400);
    send_poll(BTN_UP, 8'hCF, 8'd255, 8'd255, 32'h0005_0500);

    // random phases, each with fresh settings; every fourth one without any idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      random_config(p);
      no_idle  = (p % 4 == 2);
      clock_ms = $urandom;
      repeat (ITEMS_PER_PHASE) random_poll();
    end
    settle();

    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

[files.f]
sv/jdc_pkg.sv
sv/jdc_cfg_regs.sv
sv/jdc_shift_ctrl.sv
sv/jdc_throttle.sv
sv/jdc_ramp.sv
sv/joystick_drive_controller_unit.sv
sv/jdc_checker.sv
bench/jdc_checker.sv
bench/testbench.sv
